### sv/cde_pkg.sv
// shared types, codes and bcd conversion functions for the clock and date set editor
`default_nettype none

package cde_pkg;

  typedef enum logic [2:0] {
    CmdUp   = 3'd0,
    CmdDown = 3'd1,
    CmdNext = 3'd2,
    CmdExit = 3'd3,
    CmdLoad = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    FieldIdle    = 3'd0,
    FieldHours   = 3'd1,
    FieldMinutes = 3'd2,
    FieldSeconds = 3'd3,
    FieldDate    = 3'd4,
    FieldMonth   = 3'd5,
    FieldYear    = 3'd6
  } field_e;

  typedef logic [6:0] val_t;
  typedef logic [7:0] byte_t;

  localparam val_t ValMax     = 7'd99;
  localparam val_t HoursMax   = 7'd23;
  localparam val_t MinSecMax  = 7'd59;
  localparam val_t DateMax    = 7'd31;
  localparam val_t MonthMax   = 7'd12;
  localparam val_t DayMonthLo = 7'd1;

  typedef struct packed {
    field_e field;
    byte_t  seconds;
    byte_t  minutes;
    byte_t  hours;
    byte_t  weekday;
    byte_t  date;
    byte_t  month;
    byte_t  year;
    logic   commit;
  } result_t;

  // tens*10 + units, saturating at 99
  function automatic val_t bcd_to_bin(byte_t b);
    logic [7:0] sum;
    sum = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    return (sum > {1'b0, ValMax}) ? ValMax : sum[6:0];
  endfunction

  // tens by reciprocal multiply, valid for values up to 99
  function automatic byte_t bin_to_bcd(val_t v);
    val_t        x;
    logic [14:0] prod;
    logic [3:0]  tens;
    val_t        t10;
    val_t        units;
    x     = (v > ValMax) ? ValMax : v;
    prod  = {8'b0, x} * 15'd205;
    tens  = prod[14:11];
    t10   = {tens, 3'b000} + {2'b00, tens, 1'b0};
    units = x - t10;
    return {tens, units[3:0]};
  endfunction

  function automatic val_t field_lo(field_e f);
    case (f)
      FieldDate, FieldMonth: return DayMonthLo;
      default:               return 7'd0;
    endcase
  endfunction

  function automatic val_t field_hi(field_e f);
    case (f)
      FieldHours:   return HoursMax;
      FieldMinutes: return MinSecMax;
      FieldSeconds: return MinSecMax;
      FieldDate:    return DateMax;
      FieldMonth:   return MonthMax;
      FieldYear:    return ValMax;
      default:      return 7'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

### sv/cde_step.sv
// editor state registers and the combinational step logic for one command
`default_nettype none

module cde_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [2:0]      command_i,
  input  wire cde_pkg::byte_t  seconds_in_i,
  input  wire cde_pkg::byte_t  minutes_in_i,
  input  wire cde_pkg::byte_t  hours_in_i,
  input  wire cde_pkg::byte_t  weekday_in_i,
  input  wire cde_pkg::byte_t  date_in_i,
  input  wire cde_pkg::byte_t  month_in_i,
  input  wire cde_pkg::byte_t  year_in_i,
  output cde_pkg::result_t     result_d_o
);
  import cde_pkg::*;

  field_e field_q, field_d;
  val_t   hours_q, hours_d;
  val_t   minutes_q, minutes_d;
  val_t   seconds_q, seconds_d;
  val_t   date_q, date_d;
  val_t   month_q, month_d;
  val_t   year_q, year_d;
  byte_t  weekday_q, weekday_d;

  val_t cur_val;
  val_t lo_val;
  val_t hi_val;
  val_t upd_val;
  logic wr_en;
  logic commit_d;

  // value of the field under edit
  always_comb begin
    case (field_q)
      FieldHours:   cur_val = hours_q;
      FieldMinutes: cur_val = minutes_q;
      FieldSeconds: cur_val = seconds_q;
      FieldDate:    cur_val = date_q;
      FieldMonth:   cur_val = month_q;
      default:      cur_val = year_q;
    endcase
  end

  assign lo_val = field_lo(field_q);
  assign hi_val = field_hi(field_q);

  always_comb begin
    field_d   = field_q;
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    date_d    = date_q;
    month_d   = month_q;
    year_d    = year_q;
    weekday_d = weekday_q;
    commit_d  = 1'b0;
    wr_en     = 1'b0;
    upd_val   = cur_val;

    case (command_i)
      CmdLoad: begin
        seconds_d = bcd_to_bin(seconds_in_i);
        minutes_d = bcd_to_bin(minutes_in_i);
        hours_d   = bcd_to_bin(hours_in_i);
        weekday_d = weekday_in_i;
        date_d    = bcd_to_bin(date_in_i);
        month_d   = bcd_to_bin(month_in_i);
        year_d    = bcd_to_bin(year_in_i);
        field_d   = FieldHours;
      end
      CmdUp: begin
        if (field_q != FieldIdle) begin
          wr_en   = 1'b1;
          upd_val = (cur_val < hi_val) ? cur_val + 7'd1 : lo_val;
        end
      end
      CmdDown: begin
        if (field_q != FieldIdle) begin
          wr_en   = 1'b1;
          upd_val = (cur_val > lo_val) ? cur_val - 7'd1 : hi_val;
        end
      end
      CmdNext: begin
        if (field_q == FieldYear) begin
          field_d  = FieldIdle;
          commit_d = 1'b1;
        end else if (field_q != FieldIdle) begin
          field_d = field_e'(field_q + 3'd1);
        end
      end
      CmdExit: begin
        if (field_q != FieldIdle) begin
          field_d  = FieldIdle;
          commit_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (wr_en) begin
      case (field_q)
        FieldHours:   hours_d   = upd_val;
        FieldMinutes: minutes_d = upd_val;
        FieldSeconds: seconds_d = upd_val;
        FieldDate:    date_d    = upd_val;
        FieldMonth:   month_d   = upd_val;
        default:      year_d    = upd_val;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q   <= FieldIdle;
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
      date_q    <= '0;
      month_q   <= '0;
      year_q    <= '0;
      weekday_q <= '0;
    end else if (step_i) begin
      field_q   <= field_d;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      date_q    <= date_d;
      month_q   <= month_d;
      year_q    <= year_d;
      weekday_q <= weekday_d;
    end
  end

  // result shows the state after the step
  always_comb begin
    result_d_o.field   = field_d;
    result_d_o.seconds = bin_to_bcd(seconds_d);
    result_d_o.minutes = bin_to_bcd(minutes_d);
    result_d_o.hours   = bin_to_bcd(hours_d);
    result_d_o.weekday = weekday_d;
    result_d_o.date    = bin_to_bcd(date_d);
    result_d_o.month   = bin_to_bcd(month_d);
    result_d_o.year    = bin_to_bcd(year_d);
    result_d_o.commit  = commit_d;
  end

endmodule

`default_nettype wire

### sv/clock_date_set_editor.sv
// top level of the clock and date set editor: input register, step logic, result register
//
//   channel  | signals                    | content
//   ---------+----------------------------+-----------------------------------------
//   in       | in_valid_i / in_ready_o    | command and seven raw clock bytes
//   out      | out_valid_o / out_ready_i  | selected field, six bcd bytes, weekday, commit
//
// one transfer in and one result out per cycle while out_ready_i stays high; a result is
// offered once its input has passed the input register and then the result register
// behind the step logic
// reset clears the edit field, all values and both valid flags
// a stalled result holds in the result register while one more input waits in the
// input register; in_ready_o drops only when both are full

`default_nettype none

module clock_date_set_editor (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [2:0]     command_i,
  input  wire cde_pkg::byte_t seconds_in_i,
  input  wire cde_pkg::byte_t minutes_in_i,
  input  wire cde_pkg::byte_t hours_in_i,
  input  wire cde_pkg::byte_t weekday_in_i,
  input  wire cde_pkg::byte_t date_in_i,
  input  wire cde_pkg::byte_t month_in_i,
  input  wire cde_pkg::byte_t year_in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [2:0]          field_selected_o,
  output cde_pkg::byte_t      seconds_bcd_o,
  output cde_pkg::byte_t      minutes_bcd_o,
  output cde_pkg::byte_t      hours_bcd_o,
  output cde_pkg::byte_t      weekday_out_o,
  output cde_pkg::byte_t      date_bcd_o,
  output cde_pkg::byte_t      month_bcd_o,
  output cde_pkg::byte_t      year_bcd_o,
  output logic                commit_o
);
  import cde_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [2:0] cmd_q;
  byte_t      sec_q, min_q, hrs_q, wday_q, date_q, mon_q, year_q;
  logic       out_vld_q, out_vld_d;
  result_t    res_q;
  result_t    res_d;
  logic       step;
  logic       in_xfer;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= command_i;
      sec_q  <= seconds_in_i;
      min_q  <= minutes_in_i;
      hrs_q  <= hours_in_i;
      wday_q <= weekday_in_i;
      date_q <= date_in_i;
      mon_q  <= month_in_i;
      year_q <= year_in_i;
    end
  end

  cde_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .command_i    (cmd_q),
    .seconds_in_i (sec_q),
    .minutes_in_i (min_q),
    .hours_in_i   (hrs_q),
    .weekday_in_i (wday_q),
    .date_in_i    (date_q),
    .month_in_i   (mon_q),
    .year_in_i    (year_q),
    .result_d_o   (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign field_selected_o = res_q.field;
  assign seconds_bcd_o    = res_q.seconds;
  assign minutes_bcd_o    = res_q.minutes;
  assign hours_bcd_o      = res_q.hours;
  assign weekday_out_o    = res_q.weekday;
  assign date_bcd_o       = res_q.date;
  assign month_bcd_o      = res_q.month;
  assign year_bcd_o       = res_q.year;
  assign commit_o         = res_q.commit;

endmodule

`default_nettype wire

### tb/sv/clock_date_set_editor_tb.sv
// self-checking testbench for the clock and date set editor with a scoreboard class
`timescale 1ns / 100ps

module clock_date_set_editor_tb;
  import cde_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomKeys  = 1400;
  localparam int MaxReported = 10;

  class clock_edit_tracker;
    field_e  field;
    int      val[7];
    byte_t   weekday;
    result_t pending_displays[$];
    int      active_keys;
    int      accepted;
    int      checked;
    int      mismatches;
    int      loads;
    int      commits;

    function new();
      field = FieldIdle;
      foreach (val[i]) val[i] = 0;
      weekday = '0;
      active_keys = 0;
      accepted = 0;
      checked = 0;
      mismatches = 0;
      loads = 0;
      commits = 0;
    endfunction

    function int raw_to_val(byte_t b);
      int v;
      v = int'(b[7:4]) * 10 + int'(b[3:0]);
      return (v > 99) ? 99 : v;
    endfunction

    function byte_t val_to_bcd(int v);
      return byte_t'(((v / 10) << 4) | (v % 10));
    endfunction

    function int low_end(field_e f);
      return (f == FieldDate || f == FieldMonth) ? int'(DayMonthLo) : 0;
    endfunction

    function int high_end(field_e f);
      case (f)
        FieldHours:                 return int'(HoursMax);
        FieldMinutes, FieldSeconds: return int'(MinSecMax);
        FieldDate:                  return int'(DateMax);
        FieldMonth:                 return int'(MonthMax);
        default:                    return int'(ValMax);
      endcase
    endfunction

    function bit is_idle();
      return field == FieldIdle;
    endfunction

    function int pending_count();
      return pending_displays.size();
    endfunction

    // one accepted key transfer, one expected display
    function void note_key(logic [2:0] cmd, byte_t sec, byte_t mins, byte_t hrs, byte_t wd,
                           byte_t dt, byte_t mo, byte_t yr);
      result_t want;
      logic    done;
      field_e  f;
      done = 1'b0;
      f = field;
      accepted++;
      if (cmd == CmdLoad) begin
        val[FieldSeconds] = raw_to_val(sec);
        val[FieldMinutes] = raw_to_val(mins);
        val[FieldHours]   = raw_to_val(hrs);
        val[FieldDate]    = raw_to_val(dt);
        val[FieldMonth]   = raw_to_val(mo);
        val[FieldYear]    = raw_to_val(yr);
        weekday = wd;
        field = FieldHours;
        loads++;
        active_keys++;
      end else if (f != FieldIdle) begin
        case (cmd)
          CmdUp: begin
            val[f] = (val[f] < high_end(f)) ? val[f] + 1 : low_end(f);
            active_keys++;
          end
          CmdDown: begin
            val[f] = (val[f] > low_end(f)) ? val[f] - 1 : high_end(f);
            active_keys++;
          end
          CmdNext: begin
            if (f == FieldYear) begin
              field = FieldIdle;
              done = 1'b1;
            end else begin
              field = field_e'(int'(f) + 1);
            end
            active_keys++;
          end
          CmdExit: begin
            field = FieldIdle;
            done = 1'b1;
            active_keys++;
          end
          default: ;
        endcase
      end
      want.field   = field;
      want.seconds = val_to_bcd(val[FieldSeconds]);
      want.minutes = val_to_bcd(val[FieldMinutes]);
      want.hours   = val_to_bcd(val[FieldHours]);
      want.weekday = weekday;
      want.date    = val_to_bcd(val[FieldDate]);
      want.month   = val_to_bcd(val[FieldMonth]);
      want.year    = val_to_bcd(val[FieldYear]);
      want.commit  = done;
      pending_displays.push_back(want);
    endfunction

    function string show(result_t r);
      return $sformatf("field=%0d s=%h m=%h h=%h wd=%h d=%h mo=%h y=%h commit=%b",
                       r.field, r.seconds, r.minutes, r.hours, r.weekday, r.date,
                       r.month, r.year, r.commit);
    endfunction

    function void check_display(result_t got);
      result_t want;
      if (pending_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) $display("unexpected display: %s", show(got));
        return;
      end
      want = pending_displays.pop_front();
      checked++;
      if (want.commit) commits++;
      if (got.field !== want.field || got.seconds !== want.seconds ||
          got.minutes !== want.minutes || got.hours !== want.hours ||
          got.weekday !== want.weekday || got.date !== want.date ||
          got.month !== want.month || got.year !== want.year ||
          got.commit !== want.commit) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("display %0d mismatch", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] command = '0;
  byte_t      seconds_in = '0;
  byte_t      minutes_in = '0;
  byte_t      hours_in = '0;
  byte_t      weekday_in = '0;
  byte_t      date_in = '0;
  byte_t      month_in = '0;
  byte_t      year_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] field_selected;
  byte_t      seconds_bcd;
  byte_t      minutes_bcd;
  byte_t      hours_bcd;
  byte_t      weekday_out;
  byte_t      date_bcd;
  byte_t      month_bcd;
  byte_t      year_bcd;
  logic       commit;

  clock_edit_tracker tracker = new();
  result_t           seen_display;
  int                cycles = 0;
  int                burst_left = 0;
  int                stall_mode = 0;
  int                mode_left = 0;
  int                stall_phase = 0;
  int                random_target;

  clock_date_set_editor dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (command),
    .seconds_in_i     (seconds_in),
    .minutes_in_i     (minutes_in),
    .hours_in_i       (hours_in),
    .weekday_in_i     (weekday_in),
    .date_in_i        (date_in),
    .month_in_i       (month_in),
    .year_in_i        (year_in),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .field_selected_o (field_selected),
    .seconds_bcd_o    (seconds_bcd),
    .minutes_bcd_o    (minutes_bcd),
    .hours_bcd_o      (hours_bcd),
    .weekday_out_o    (weekday_out),
    .date_bcd_o       (date_bcd),
    .month_bcd_o      (month_bcd),
    .year_bcd_o       (year_bcd),
    .commit_o         (commit)
  );

  always #5 clk = ~clk;

  // receiver stall pattern, with a new random mode chosen whenever the mode counter runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    stall_phase++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (stall_phase % 5) != 0;
      3:       out_ready <= (stall_phase % 4) == 0;
      default: out_ready <= $urandom_range(0, 9) != 0;
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d displays outstanding", cycles,
               tracker.pending_count());
      $display("Test completed with failures");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      seen_display.field   = field_e'(field_selected);
      seen_display.seconds = seconds_bcd;
      seen_display.minutes = minutes_bcd;
      seen_display.hours   = hours_bcd;
      seen_display.weekday = weekday_out;
      seen_display.date    = date_bcd;
      seen_display.month   = month_bcd;
      seen_display.year    = year_bcd;
      seen_display.commit  = commit;
      tracker.check_display(seen_display);
    end
  end

  task automatic send_key(logic [2:0] cmd, byte_t sec, byte_t mins, byte_t hrs, byte_t wd,
                          byte_t dt, byte_t mo, byte_t yr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    seconds_in <= sec;
    minutes_in <= mins;
    hours_in   <= hrs;
    weekday_in <= wd;
    date_in    <= dt;
    month_in   <= mo;
    year_in    <= yr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_key(cmd, sec, mins, hrs, wd, dt, mo, yr);
    burst_left--;
  endtask

  task automatic send_cmd(logic [2:0] cmd);
    send_key(cmd, byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
             byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
             byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
             byte_t'($urandom_range(0, 255)));
  endtask

  // mostly valid bcd, some at or above the top of the field range, some raw bytes
  function automatic byte_t pick_byte(int hi);
    case ($urandom_range(0, 3))
      0, 1:    return tracker.val_to_bcd($urandom_range(0, hi));
      2:       return byte_t'($urandom_range(0, 255));
      default: return tracker.val_to_bcd($urandom_range(0, 1) ? hi : $urandom_range(hi, 99));
    endcase
  endfunction

  task automatic send_load_random();
    send_key(CmdLoad, pick_byte(59), pick_byte(59), pick_byte(23),
             byte_t'($urandom_range(0, 255)), pick_byte(31), pick_byte(12), pick_byte(99));
  endtask

  task automatic edit_session(int target);
    int up_pct;
    int roll;
    int idle_noise;
    int pick;
    case ($urandom_range(0, 2))
      0:       up_pct = 10;
      1:       up_pct = 50;
      default: up_pct = 90;
    endcase
    idle_noise = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    repeat (idle_noise) begin
      pick = $urandom_range(0, 6);
      if (pick >= int'(CmdLoad)) pick++;
      send_cmd(3'(pick));
    end
    send_load_random();
    while (!tracker.is_idle() && tracker.active_keys < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) send_load_random();
      else if (roll < 6) send_cmd(CmdExit);
      else if (roll < 10) send_cmd(3'($urandom_range(5, 7)));
      else if (roll < 25) send_cmd(CmdNext);
      else if ($urandom_range(1, 100) <= up_pct) send_cmd(CmdUp);
      else send_cmd(CmdDown);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle keys and unused codes are ignored
    send_cmd(CmdUp);
    send_cmd(CmdExit);
    send_cmd(3'd5);
    // all bytes saturate, every field except minutes steps across its wrap
    send_key(CmdLoad, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(CmdUp);
    send_cmd(CmdDown);
    send_cmd(CmdUp);
    send_cmd(3'd6);
    send_cmd(CmdNext);
    send_cmd(CmdDown);
    send_cmd(CmdNext);
    send_cmd(CmdUp);
    send_cmd(CmdNext);
    send_cmd(CmdUp);
    send_cmd(CmdDown);
    send_cmd(CmdNext);
    send_cmd(CmdUp);
    send_cmd(CmdNext);
    send_cmd(CmdUp);
    send_cmd(CmdDown);
    send_cmd(CmdNext);
    // zero bytes, then a reload during editing with digits above nine
    send_key(CmdLoad, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(CmdDown);
    send_key(CmdLoad, 8'h9A, 8'h5F, 8'h23, 8'hA5, 8'h31, 8'h12, 8'h99);
    send_cmd(3'd7);
    send_cmd(CmdExit);

    random_target = tracker.active_keys + RandomKeys;
    while (tracker.active_keys < random_target) edit_session(random_target);

    in_valid <= 1'b0;
    while (tracker.pending_count() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d key transfers (%0d effective), %0d loads, %0d commits", tracker.accepted,
             tracker.active_keys, tracker.loads, tracker.commits);
    $display("%0d displays checked, %0d mismatches", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
sv/cde_pkg.sv
sv/cde_step.sv
sv/clock_date_set_editor.sv
tb/sv/clock_date_set_editor_tb.sv
